// ===== hdl/scp_pkg.sv =====
package scp_pkg;

	localparam logic [1:0] ACT_BYTE  = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [2:0] REG_PREAMBLE = 3'd0;
	localparam logic [2:0] REG_COUNT    = 3'd1;
	localparam logic [2:0] REG_NAME0    = 3'd2;

	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;

	typedef enum logic [1:0] {
		PH_PREAMBLE = 2'd0,
		PH_NAME     = 2'd1,
		PH_PARAM    = 2'd2,
		PH_DONE     = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_PRE,
		SQ_NAME,
		SQ_PARAM,
		SQ_CLEAR,
		SQ_DONE
	} seq_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] byte_value;
		logic [5:0] read_address;
	} cmd_t;

	typedef struct packed {
		logic       message_ready;
		logic [2:0] command_index;
		logic [1:0] parse_state;
		logic       stored;
		logic [5:0] stored_position;
		logic [7:0] read_data;
		logic       overflow;
	} res_t;

	typedef struct packed {
		logic       preamble_enable;
		logic [3:0] cur_len;
		logic [7:0] cur_char;
		logic       whole_hit;
		logic [2:0] whole_entry;
		logic       char_hit;
		logic [2:0] char_entry;
	} name_status_t;

	function automatic logic is_sep(input logic [7:0] c);
		return (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_EQUAL);
	endfunction

endpackage

// ===== hdl/scp_store.sv =====
module scp_store #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [7:0]               wr_data,
	input  logic                     rd_en,
	input  logic                     rd_in_range,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [7:0]               rd_data
);

	logic [7:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0] rd_data_q;
	logic rd_ok_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// An entry that was never written since the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (clear) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_ok_q <= rd_in_range && vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_ok_q ? rd_data_q : 8'd0;

endmodule

// ===== hdl/scp_names.sv =====
module scp_names #(
	parameter int NAME_LEN = 8,
	parameter int MAX_COMMANDS = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [63:0]                cfg_data,
	input  logic [2:0]                 match_entry,
	input  logic [3:0]                 prefix_len,
	input  logic [7:0]                 byte_value,
	output scp_pkg::name_status_t      status
);

	logic pre_en_q;
	logic [2:0] count_q;
	logic [NAME_LEN-1:0][7:0] name_q [MAX_COMMANDS];

	logic [3:0] len [MAX_COMMANDS];
	logic [NAME_LEN-1:0][7:0] cur;
	logic [2:0] cnt;
	logic same [MAX_COMMANDS];
	logic [7:0] nchar [MAX_COMMANDS];
	logic elig [MAX_COMMANDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_en_q <= 1'b1;
			count_q <= 3'd1;
			for (int e = 0; e < MAX_COMMANDS; e++) begin
				name_q[e] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == scp_pkg::REG_PREAMBLE) begin
				pre_en_q <= cfg_data[0];
			end
			if (cfg_index == scp_pkg::REG_COUNT) begin
				count_q <= cfg_data[2:0];
			end
			for (int e = 0; e < MAX_COMMANDS; e++) begin
				if (cfg_index == scp_pkg::REG_NAME0 + 3'(e)) begin
					name_q[e] <= cfg_data[8*NAME_LEN-1:0];
				end
			end
		end
	end

	// A name ends at its first zero byte.
	always_comb begin
		for (int e = 0; e < MAX_COMMANDS; e++) begin
			len[e] = 4'(NAME_LEN);
			for (int k = NAME_LEN - 1; k >= 0; k--) begin
				if (name_q[e][k] == 8'd0) begin
					len[e] = 4'(k);
				end
			end
		end
	end

	always_comb begin
		cur = name_q[0];
		status.cur_len = len[0];
		for (int e = 0; e < MAX_COMMANDS; e++) begin
			if (match_entry == 3'(e)) begin
				cur = name_q[e];
				status.cur_len = len[e];
			end
		end
		status.cur_char = 8'd0;
		for (int k = 0; k < NAME_LEN; k++) begin
			if (prefix_len == 4'(k)) begin
				status.cur_char = cur[k];
			end
		end
		status.preamble_enable = pre_en_q;

		// Later entries that share the prefix matched so far; the lowest one wins.
		cnt = (count_q > 3'(MAX_COMMANDS)) ? 3'(MAX_COMMANDS) : count_q;
		status.whole_hit = 1'b0;
		status.whole_entry = 3'd0;
		status.char_hit = 1'b0;
		status.char_entry = 3'd0;
		for (int n = 0; n < MAX_COMMANDS; n++) begin
			same[n] = 1'b1;
			nchar[n] = 8'd0;
			for (int k = 0; k < NAME_LEN; k++) begin
				if ((4'(k) < prefix_len) && (cur[k] != name_q[n][k])) begin
					same[n] = 1'b0;
				end
				if (prefix_len == 4'(k)) begin
					nchar[n] = name_q[n][k];
				end
			end
			elig[n] = (3'(n) > match_entry) && (3'(n) < cnt) && same[n];
			if (elig[n] && (len[n] == prefix_len) && !status.whole_hit) begin
				status.whole_hit = 1'b1;
				status.whole_entry = 3'(n);
			end
			if (elig[n] && (prefix_len < len[n]) && (nchar[n] == byte_value)
				&& !status.char_hit) begin
				status.char_hit = 1'b1;
				status.char_entry = 3'(n);
			end
		end
	end

endmodule

// ===== hdl/serial_command_parser.sv =====
// Parses a serial command stream one word at a time: an optional "$%" preamble, a
// command name matched against six configurable names, then parameter bytes that are
// kept in an on-chip byte store (separators stored as zero) until "$%" completes the
// message. Every accepted word returns exactly one result word. One word is worked on
// at a time: it is accepted, then takes one parse step per state (none for read and
// other non-byte, non-clear words, one for parameter bytes and clears, up to four
// when a name mismatch sends the byte back through the preamble check), then loads
// the output register, which waits while res_stall holds the previous result.
// Reads use a registered store port that is read when the word is accepted. A clear
// empties the store at once through per-entry valid bits, so there is no clearing pass
// after reset or clear. A finished result waits in the output register while the next
// word is accepted.
module serial_command_parser #(
	parameter int MSG_SIZE = 64,
	parameter int NAME_LEN = 8,
	parameter int MAX_COMMANDS = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  scp_pkg::cmd_t   cmd,
	output logic            res_valid,
	input  logic            res_stall,
	output scp_pkg::res_t   res,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [63:0]     cfg_data
);

	localparam int PW = $clog2(MSG_SIZE + 1);
	localparam int AW = $clog2(MSG_SIZE);

	scp_pkg::seq_t state_q, state_d;
	scp_pkg::phase_t phase_q, phase_d;
	logic [2:0] match_q, match_d;
	logic [PW-1:0] pos_q, pos_d;
	logic dollar_q, dollar_d;
	logic pseen_q, pseen_d;
	logic ready_q, ready_d;

	logic [1:0] act_q;
	logic [7:0] byte_q;
	logic stored_q, stored_d;
	logic [5:0] spos_q, spos_d;
	logic ovf_q, ovf_d;

	logic res_valid_q;
	scp_pkg::res_t res_q;

	scp_pkg::name_status_t nst;

	logic accept, load, again, cfg_restart;
	logic do_write, do_restart, do_finish, do_params, keep_pos;
	logic [7:0] write_val;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic rd_en, rd_in_range;
	logic [7:0] rd_data;

	scp_names #(
		.NAME_LEN(NAME_LEN),
		.MAX_COMMANDS(MAX_COMMANDS)
	) u_names (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.match_entry(match_q),
		.prefix_len(4'(pos_q)),
		.byte_value(byte_q),
		.status(nst)
	);

	scp_store #(
		.DEPTH(MSG_SIZE)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.clear(state_q == scp_pkg::SQ_CLEAR),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(write_val),
		.rd_en(rd_en),
		.rd_in_range(rd_in_range),
		.rd_addr(AW'(cmd.read_address)),
		.rd_data(rd_data)
	);

	assign cfg_restart = cfg_we && (cfg_index == scp_pkg::REG_PREAMBLE);
	assign rd_in_range = 32'(cmd.read_address) < 32'(MSG_SIZE);

	always_comb begin
		cmd_stall = (state_q != scp_pkg::SQ_IDLE);
		accept = cmd_valid && !cmd_stall;
		rd_en = accept && (cmd.action == scp_pkg::ACT_READ);
		load = (state_q == scp_pkg::SQ_DONE) && (!res_valid_q || !res_stall);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scp_pkg::SQ_IDLE: begin
				if (accept) begin
					if (cmd.action == scp_pkg::ACT_BYTE) begin
						if (ready_q) begin
							state_d = scp_pkg::SQ_DONE;
						end else begin
							unique case (phase_q)
								scp_pkg::PH_PREAMBLE: state_d = scp_pkg::SQ_PRE;
								scp_pkg::PH_NAME:     state_d = scp_pkg::SQ_NAME;
								scp_pkg::PH_PARAM:    state_d = scp_pkg::SQ_PARAM;
								scp_pkg::PH_DONE:     state_d = scp_pkg::SQ_DONE;
							endcase
						end
					end else if (cmd.action == scp_pkg::ACT_CLEAR) begin
						state_d = scp_pkg::SQ_CLEAR;
					end else begin
						state_d = scp_pkg::SQ_DONE;
					end
				end
			end
			scp_pkg::SQ_PRE:   state_d = again ? scp_pkg::SQ_NAME : scp_pkg::SQ_DONE;
			scp_pkg::SQ_NAME:  state_d = again ? scp_pkg::SQ_PRE : scp_pkg::SQ_DONE;
			scp_pkg::SQ_PARAM: state_d = scp_pkg::SQ_DONE;
			scp_pkg::SQ_CLEAR: state_d = scp_pkg::SQ_DONE;
			scp_pkg::SQ_DONE:  state_d = load ? scp_pkg::SQ_IDLE : scp_pkg::SQ_DONE;
			default:           state_d = scp_pkg::SQ_IDLE;
		endcase
	end

	// One parse step on the held byte per cycle.
	always_comb begin
		phase_d = phase_q;
		match_d = match_q;
		pos_d = pos_q;
		dollar_d = dollar_q;
		pseen_d = pseen_q;
		ready_d = ready_q;
		stored_d = stored_q;
		spos_d = spos_q;
		ovf_d = ovf_q;
		again = 1'b0;
		do_write = 1'b0;
		do_restart = 1'b0;
		do_finish = 1'b0;
		do_params = 1'b0;
		keep_pos = 1'b0;
		write_val = 8'd0;
		wr_en = 1'b0;
		wr_addr = AW'(pos_q);
		unique case (state_q)
			scp_pkg::SQ_PRE: begin
				if (byte_q == scp_pkg::CH_DOLLAR) begin
					dollar_d = 1'b1;
				end else if (dollar_q && (byte_q == scp_pkg::CH_PERCENT)) begin
					pseen_d = 1'b1;
					dollar_d = 1'b0;
				end else begin
					dollar_d = 1'b0;
					if (pseen_q) begin
						pseen_d = 1'b0;
						phase_d = scp_pkg::PH_NAME;
						match_d = 3'd0;
						pos_d = '0;
						again = 1'b1;
					end
				end
			end
			scp_pkg::SQ_NAME: begin
				if ((4'(pos_q) < nst.cur_len) && (byte_q == nst.cur_char)) begin
					pos_d = pos_q + PW'(1);
				end else if (byte_q == scp_pkg::CH_DOLLAR) begin
					dollar_d = 1'b1;
				end else if ((dollar_q && (byte_q == scp_pkg::CH_PERCENT))
					|| scp_pkg::is_sep(byte_q)) begin
					dollar_d = 1'b0;
					if ((4'(pos_q) == nst.cur_len) || nst.whole_hit) begin
						if (4'(pos_q) != nst.cur_len) begin
							match_d = nst.whole_entry;
						end
						do_finish = !scp_pkg::is_sep(byte_q);
						do_params = scp_pkg::is_sep(byte_q);
					end else begin
						do_restart = 1'b1;
					end
				end else begin
					dollar_d = 1'b0;
					if (nst.char_hit) begin
						match_d = nst.char_entry;
						pos_d = pos_q + PW'(1);
					end else begin
						do_restart = 1'b1;
						again = 1'b1;
					end
				end
			end
			scp_pkg::SQ_PARAM: begin
				if (scp_pkg::is_sep(byte_q)) begin
					do_write = 1'b1;
				end else if (byte_q == scp_pkg::CH_DOLLAR) begin
					dollar_d = 1'b1;
				end else if (dollar_q && (byte_q == scp_pkg::CH_PERCENT)) begin
					do_write = 1'b1;
					keep_pos = 1'b1;
					do_finish = 1'b1;
					dollar_d = 1'b0;
				end else begin
					dollar_d = 1'b0;
					do_write = 1'b1;
					write_val = byte_q;
				end
			end
			scp_pkg::SQ_CLEAR: begin
				do_restart = 1'b1;
			end
			default: begin
			end
		endcase

		if (do_write) begin
			if (pos_q < PW'(MSG_SIZE)) begin
				wr_en = 1'b1;
				stored_d = 1'b1;
				spos_d = 6'(pos_q);
				pos_d = keep_pos ? pos_q : pos_q + PW'(1);
			end else begin
				pos_d = PW'(MSG_SIZE);
				ovf_d = 1'b1;
			end
		end
		if (do_params) begin
			phase_d = scp_pkg::PH_PARAM;
			pos_d = '0;
		end
		if (do_finish) begin
			phase_d = scp_pkg::PH_DONE;
			ready_d = 1'b1;
		end
		if (do_restart) begin
			ready_d = 1'b0;
			phase_d = nst.preamble_enable ? scp_pkg::PH_PREAMBLE : scp_pkg::PH_NAME;
			match_d = 3'd0;
			pos_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scp_pkg::SQ_IDLE;
			phase_q <= scp_pkg::PH_PREAMBLE;
			match_q <= 3'd0;
			pos_q <= '0;
			dollar_q <= 1'b0;
			pseen_q <= 1'b0;
			ready_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_restart) begin
				ready_q <= 1'b0;
				phase_q <= cfg_data[0] ? scp_pkg::PH_PREAMBLE : scp_pkg::PH_NAME;
				match_q <= 3'd0;
				pos_q <= '0;
			end else if (state_q != scp_pkg::SQ_IDLE) begin
				phase_q <= phase_d;
				match_q <= match_d;
				pos_q <= pos_d;
				ready_q <= ready_d;
			end
			if (state_q != scp_pkg::SQ_IDLE) begin
				dollar_q <= dollar_d;
				pseen_q <= pseen_d;
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= cmd.action;
			byte_q <= cmd.byte_value;
			stored_q <= 1'b0;
			spos_q <= 6'd0;
			ovf_q <= 1'b0;
		end else if (state_q != scp_pkg::SQ_IDLE) begin
			stored_q <= stored_d;
			spos_q <= spos_d;
			ovf_q <= ovf_d;
		end
		if (load) begin
			res_q.message_ready <= ready_q;
			res_q.command_index <= match_q;
			res_q.parse_state <= phase_q;
			res_q.stored <= stored_q;
			res_q.stored_position <= spos_q;
			res_q.read_data <= (act_q == scp_pkg::ACT_READ) ? rd_data : 8'd0;
			res_q.overflow <= ovf_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

// ===== tb/scp_result_checker.sv =====
`timescale 1ns / 1ps

module scp_result_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  logic            cmd_stall,
	input  scp_pkg::cmd_t   cmd,
	input  logic            res_valid,
	input  logic            res_stall,
	input  scp_pkg::res_t   res,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [63:0]     cfg_data,
	output int              mismatches,
	output int              pending,
	output int              checked,
	output int              stored_total,
	output int              dropped_total
);

	logic        pre_en;
	logic [2:0]  cmd_count;
	logic [63:0] name_tab [6];

	scp_pkg::phase_t ph;
	logic [2:0]  entry;
	logic [6:0]  pos;
	logic        dollar;
	logic        pre_seen;
	logic        ready;
	logic [7:0]  mem [64];

	logic        st_flag;
	logic [5:0]  st_pos;
	logic        ovf_flag;

	scp_pkg::res_t status_due [$];
	int          fails;
	int          n_checked;
	int          n_stored;
	int          n_dropped;

	function automatic logic [7:0] char_at(int e, int k);
		if (e > 5 || k > 7) return 8'h00;
		return name_tab[e][8*k +: 8];
	endfunction

	function automatic int len_of(int e);
		int k;
		for (k = 0; k < 8; k++) begin
			if (char_at(e, k) == 8'h00) return k;
		end
		return 8;
	endfunction

	function automatic logic is_separator(logic [7:0] c);
		return c inside {scp_pkg::CH_COMMA, scp_pkg::CH_SEMI, scp_pkg::CH_EQUAL};
	endfunction

	function automatic void restart_parse();
		ready = 1'b0;
		ph = pre_en ? scp_pkg::PH_PREAMBLE : scp_pkg::PH_NAME;
		entry = 3'd0;
		pos = 7'd0;
	endfunction

	// Moves to a later table entry that shares the prefix matched so far.
	function automatic logic advance_entry(logic whole, logic [7:0] c);
		int cnt;
		int n;
		int k;
		logic same;
		cnt = (cmd_count > 3'd6) ? 6 : int'(cmd_count);
		for (n = int'(entry) + 1; n < cnt; n++) begin
			same = 1'b1;
			for (k = 0; k < int'(pos) && k < 8; k++) begin
				if (char_at(int'(entry), k) != char_at(n, k)) begin
					same = 1'b0;
					break;
				end
			end
			if (same && (whole ? (len_of(n) == int'(pos))
					: (int'(pos) < len_of(n) && char_at(n, int'(pos)) == c))) begin
				entry = 3'(n);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic preamble_step(logic [7:0] c);
		if (c == scp_pkg::CH_DOLLAR) begin
			dollar = 1'b1;
		end else if (dollar && c == scp_pkg::CH_PERCENT) begin
			pre_seen = 1'b1;
			dollar = 1'b0;
		end else begin
			dollar = 1'b0;
			if (pre_seen) begin
				pre_seen = 1'b0;
				ph = scp_pkg::PH_NAME;
				entry = 3'd0;
				pos = 7'd0;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic name_step(logic [7:0] c);
		int len;
		len = len_of(int'(entry));
		if (int'(pos) < len && c == char_at(int'(entry), int'(pos))) begin
			pos++;
			return 1'b0;
		end
		if (c == scp_pkg::CH_DOLLAR) begin
			dollar = 1'b1;
			return 1'b0;
		end
		if (dollar && c == scp_pkg::CH_PERCENT) begin
			dollar = 1'b0;
			if (int'(pos) == len || advance_entry(1'b1, 8'h00)) begin
				ph = scp_pkg::PH_DONE;
				ready = 1'b1;
			end else begin
				restart_parse();
			end
			return 1'b0;
		end
		if (is_separator(c)) begin
			dollar = 1'b0;
			if (int'(pos) == len || advance_entry(1'b1, 8'h00)) begin
				ph = scp_pkg::PH_PARAM;
				pos = 7'd0;
			end else begin
				restart_parse();
			end
			return 1'b0;
		end
		dollar = 1'b0;
		if (advance_entry(1'b0, c)) begin
			pos++;
			return 1'b0;
		end
		restart_parse();
		return 1'b1;
	endfunction

	function automatic void store_put(logic [7:0] v);
		if (pos < 7'd64) begin
			mem[pos[5:0]] = v;
			st_flag = 1'b1;
			st_pos = pos[5:0];
			pos++;
		end else begin
			pos = 7'd64;
			ovf_flag = 1'b1;
		end
	endfunction

	function automatic void param_step(logic [7:0] c);
		logic [6:0] keep;
		if (is_separator(c)) begin
			store_put(8'h00);
		end else if (c == scp_pkg::CH_DOLLAR) begin
			dollar = 1'b1;
		end else if (dollar && c == scp_pkg::CH_PERCENT) begin
			keep = pos;
			store_put(8'h00);
			pos = keep;
			ph = scp_pkg::PH_DONE;
			ready = 1'b1;
			dollar = 1'b0;
		end else begin
			dollar = 1'b0;
			store_put(c);
		end
	endfunction

	function automatic void feed_byte(logic [7:0] c);
		logic as_name;
		int k;
		if (ready) return;
		if (ph == scp_pkg::PH_PARAM) begin
			param_step(c);
			return;
		end
		if (ph == scp_pkg::PH_DONE) return;
		as_name = (ph == scp_pkg::PH_NAME);
		for (k = 0; k < 4; k++) begin
			if (!as_name) begin
				if (!preamble_step(c)) break;
				as_name = 1'b1;
			end else begin
				if (!name_step(c)) break;
				as_name = 1'b0;
			end
		end
	endfunction

	function automatic scp_pkg::res_t parse_word(scp_pkg::cmd_t w);
		scp_pkg::res_t r;
		logic [7:0] rd;
		int i;
		st_flag = 1'b0;
		st_pos = 6'd0;
		ovf_flag = 1'b0;
		rd = 8'h00;
		case (w.action)
			scp_pkg::ACT_BYTE: feed_byte(w.byte_value);
			scp_pkg::ACT_CLEAR: begin
				restart_parse();
				for (i = 0; i < 64; i++) mem[i] = 8'h00;
			end
			scp_pkg::ACT_READ: rd = mem[w.read_address];
			default: ;
		endcase
		r.message_ready   = ready;
		r.command_index   = entry;
		r.parse_state     = ph;
		r.stored          = st_flag;
		r.stored_position = st_pos;
		r.read_data       = rd;
		r.overflow        = ovf_flag;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		fails++;
	endtask

	task automatic check_status(input scp_pkg::res_t got, input scp_pkg::res_t want);
		if (got.message_ready !== want.message_ready)
			flag_mismatch("message_ready", got.message_ready, want.message_ready);
		if (got.command_index !== want.command_index)
			flag_mismatch("command_index", got.command_index, want.command_index);
		if (got.parse_state !== want.parse_state)
			flag_mismatch("parse_state", got.parse_state, want.parse_state);
		if (got.stored !== want.stored)
			flag_mismatch("stored", got.stored, want.stored);
		if (got.stored_position !== want.stored_position)
			flag_mismatch("stored_position", got.stored_position, want.stored_position);
		if (got.read_data !== want.read_data)
			flag_mismatch("read_data", got.read_data, want.read_data);
		if (got.overflow !== want.overflow)
			flag_mismatch("overflow", got.overflow, want.overflow);
	endtask

	always @(posedge clk or negedge arst_n) begin
		scp_pkg::res_t want;
		int i;
		if (!arst_n) begin
			pre_en = 1'b1;
			cmd_count = 3'd1;
			for (i = 0; i < 6; i++) name_tab[i] = 64'd0;
			for (i = 0; i < 64; i++) mem[i] = 8'h00;
			dollar = 1'b0;
			pre_seen = 1'b0;
			restart_parse();
			status_due.delete();
			fails = 0;
			n_checked = 0;
			n_stored = 0;
			n_dropped = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == scp_pkg::REG_PREAMBLE) begin
					pre_en = cfg_data[0];
					restart_parse();
				end else if (cfg_index == scp_pkg::REG_COUNT) begin
					cmd_count = cfg_data[2:0];
				end else begin
					name_tab[cfg_index - scp_pkg::REG_NAME0] = cfg_data;
				end
			end
			if (res_valid && !res_stall) begin
				if (status_due.size() == 0) begin
					flag_mismatch("unexpected result word", 32'(res), 32'd0);
				end else begin
					want = status_due.pop_front();
					check_status(res, want);
					n_checked++;
				end
			end
			if (cmd_valid && !cmd_stall) begin
				want = parse_word(cmd);
				status_due.push_back(want);
				n_stored += int'(want.stored);
				n_dropped += int'(want.overflow);
			end
		end
		mismatches    <= fails;
		pending       <= status_due.size();
		checked       <= n_checked;
		stored_total  <= n_stored;
		dropped_total <= n_dropped;
	end

endmodule

// ===== tb/tb_serial_command_parser.sv =====
`timescale 1ns / 1ps

module tb_serial_command_parser;

	localparam logic [1:0] ACT_NONE = 2'd3;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cmd_valid = 1'b0;
	scp_pkg::cmd_t cmd = '0;
	logic          res_stall = 1'b0;
	logic          cfg_we = 1'b0;
	logic [2:0]    cfg_index = 3'd0;
	logic [63:0]   cfg_data = 64'd0;
	logic          cmd_stall;
	logic          res_valid;
	scp_pkg::res_t res;

	logic        idle_on = 1'b1;
	int          mismatches;
	int          pending;
	int          checked;
	int          stored_total;
	int          dropped_total;
	int          words_sent = 0;
	int          settings_used = 0;
	logic        cur_pre;
	int          cur_count;
	logic [63:0] name_set [6];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	serial_command_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	scp_result_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.cmd           (cmd),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.res           (res),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.pending       (pending),
		.checked       (checked),
		.stored_total  (stored_total),
		.dropped_total (dropped_total)
	);

	task automatic send_word(input scp_pkg::cmd_t w);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (cmd_stall);
		words_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_word(scp_pkg::cmd_t'{scp_pkg::ACT_BYTE, s[i], 6'($urandom)});
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic pre, input int count);
		int i;
		for (i = 0; i < 6; i++) write_reg(scp_pkg::REG_NAME0 + 3'(i), name_set[i]);
		write_reg(scp_pkg::REG_COUNT, 64'(count));
		write_reg(scp_pkg::REG_PREAMBLE, {63'd0, pre});
		cfg_we <= 1'b0;
		cur_pre = pre;
		cur_count = count;
		settings_used++;
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [63:0] text_name(input string s);
		logic [63:0] v;
		int i;
		v = 64'd0;
		for (i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
		return v;
	endfunction

	function automatic logic [63:0] random_name(input logic [63:0] prev);
		string letters;
		logic [63:0] v;
		int len;
		int share;
		int k;
		letters = "SEGO";
		v = 64'd0;
		len = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
		share = $urandom_range(0, 1) ? $urandom_range(0, len) : 0;
		for (k = 0; k < len; k++) begin
			if (k < share && prev[8*k +: 8] != 8'h00)
				v[8*k +: 8] = prev[8*k +: 8];
			else
				v[8*k +: 8] = letters[$urandom_range(0, 3)];
		end
		return v;
	endfunction

	// A well-formed message most of the time, with occasional damage, reads and a clear.
	task automatic send_message();
		scp_pkg::cmd_t seq [$];
		string pool;
		logic [7:0] ch;
		int e;
		int k;
		int np;
		pool = "SEGOX$%,;=";
		e = $urandom_range(0, cur_count - 1);
		if (cur_pre ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 5) == 0)) begin
			seq.push_back(scp_pkg::cmd_t'{scp_pkg::ACT_BYTE, scp_pkg::CH_DOLLAR,
				6'($urandom)});
			seq.push_back(scp_pkg::cmd_t'{scp_pkg::ACT_BYTE, scp_pkg::CH_PERCENT,
				6'($urandom)});
		end
		for (k = 0; k < 8 && name_set[e][8*k +: 8] != 8'h00; k++) begin
			ch = name_set[e][8*k +: 8];
			if ($urandom_range(0, 19) == 0) ch = pool[$urandom_range(0, 4)];
			if ($urandom_range(0, 24) == 0) break;
			seq.push_back(scp_pkg::cmd_t'{scp_pkg::ACT_BYTE, ch, 6'($urandom)});
		end
		if ($urandom_range(0, 5) == 0) begin
			seq.push_back(scp_pkg::cmd_t'{scp_pkg::ACT_BYTE, scp_pkg::CH_DOLLAR,
				6'($urandom)});
			seq.push_back(scp_pkg::cmd_t'{scp_pkg::ACT_BYTE, scp_pkg::CH_PERCENT,
				6'($urandom)});
		end else begin
			seq.push_back(scp_pkg::cmd_t'{scp_pkg::ACT_BYTE, pool[$urandom_range(7, 9)],
				6'($urandom)});
			np = ($urandom_range(0, 9) == 0) ? $urandom_range(58, 72) : $urandom_range(0, 10);
			for (k = 0; k < np; k++) begin
				ch = ($urandom_range(0, 2) == 0) ? 8'($urandom) : pool[$urandom_range(0, 9)];
				seq.push_back(scp_pkg::cmd_t'{scp_pkg::ACT_BYTE, ch, 6'($urandom)});
			end
			if ($urandom_range(0, 9) != 0) begin
				seq.push_back(scp_pkg::cmd_t'{scp_pkg::ACT_BYTE, scp_pkg::CH_DOLLAR,
					6'($urandom)});
				seq.push_back(scp_pkg::cmd_t'{scp_pkg::ACT_BYTE, scp_pkg::CH_PERCENT,
					6'($urandom)});
			end
		end
		repeat ($urandom_range(0, 2))
			seq.push_back(scp_pkg::cmd_t'{scp_pkg::ACT_BYTE, pool[$urandom_range(0, 9)],
				6'($urandom)});
		repeat ($urandom_range(0, 3))
			seq.push_back(scp_pkg::cmd_t'{scp_pkg::ACT_READ, 8'($urandom),
				6'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 63))});
		if ($urandom_range(0, 3) != 0)
			seq.push_back(scp_pkg::cmd_t'{scp_pkg::ACT_CLEAR, 8'($urandom), 6'($urandom)});
		foreach (seq[i]) send_word(seq[i]);
	endtask

	initial begin
		int gap;
		int next_hold;
		next_hold = 500;
		forever begin
			if (checked >= next_hold && next_hold <= 1000) begin
				gap = 150;
				next_hold += 500;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 14);
			end else begin
				gap = 0;
			end
			if (gap > 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
		end
	end

	initial begin
		#2_000_000;
		$display("FAIL serial_command_parser");
		$finish;
	end

	initial begin
		int p;
		int i;
		int target;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		name_set[0] = text_name("SET");
		name_set[1] = text_name("SETX");
		name_set[2] = text_name("GO");
		name_set[3] = text_name("GET");
		name_set[4] = text_name("ABCDEFGH");
		name_set[5] = text_name("S");
		apply_setting(1'b1, 6);

		send_word(scp_pkg::cmd_t'{scp_pkg::ACT_READ, 8'h00, 6'd63});
		send_word(scp_pkg::cmd_t'{ACT_NONE, 8'hFF, 6'h2A});
		send_text("$%SETX=");
		send_word(scp_pkg::cmd_t'{scp_pkg::ACT_BYTE, 8'hFF, 6'h15});
		send_word(scp_pkg::cmd_t'{scp_pkg::ACT_BYTE, 8'h00, 6'h3F});
		send_word(scp_pkg::cmd_t'{scp_pkg::ACT_BYTE, scp_pkg::CH_COMMA, 6'h00});
		send_text("$A$%Z");
		send_word(scp_pkg::cmd_t'{scp_pkg::ACT_READ, 8'h00, 6'd0});
		send_word(scp_pkg::cmd_t'{scp_pkg::ACT_READ, 8'h00, 6'd3});
		send_word(scp_pkg::cmd_t'{scp_pkg::ACT_CLEAR, 8'h00, 6'd0});
		send_word(scp_pkg::cmd_t'{scp_pkg::ACT_READ, 8'h00, 6'd0});
		send_text("$%SQ");
		send_word(scp_pkg::cmd_t'{scp_pkg::ACT_CLEAR, 8'hAA, 6'h15});

		for (p = 0; p < 6; p++) begin
			settle();
			idle_on <= (p != 2 && p != 5);
			for (i = 0; i < 6; i++)
				name_set[i] = random_name((i == 0) ? 64'd0 : name_set[i-1]);
			if (p == 4) begin
				name_set[0] = '1;
				name_set[1] = {$urandom, $urandom};
				name_set[2] = 64'd0;
			end
			apply_setting(p % 2 == 0,
				(p == 1) ? 1 : (p == 0 || p == 3) ? 6 : $urandom_range(1, 6));
			target = words_sent + 250;
			while (words_sent < target) begin
				if ($urandom_range(0, 9) < 7)
					send_message();
				else
					send_word(scp_pkg::cmd_t'{2'($urandom), 8'($urandom), 6'($urandom)});
			end
		end
		settle();

		$display("Sent %0d words under %0d register settings; %0d results compared.",
			words_sent, settings_used, checked);
		$display("Parameter bytes written to the store: %0d; dropped at a full store: %0d.",
			stored_total, dropped_total);
		if (mismatches == 0) begin
			$display("PASS serial_command_parser");
		end else begin
			$display("FAIL serial_command_parser");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/scp_pkg.sv
hdl/scp_store.sv
hdl/scp_names.sv
hdl/serial_command_parser.sv
tb/scp_result_checker.sv
tb/tb_serial_command_parser.sv
